// ===== design/tksi_pkg.sv =====
// ----------------------------------------------------------------------------
// tksi_pkg: shared types and constants for the top-k sorted insert block
// Table geometry, field widths, function codes and helper functions.
// ----------------------------------------------------------------------------
package tksi_pkg;

    localparam int TABLE_ENTRIES = 10;
    localparam int NAME_CHARS    = 8;

    localparam int FUNC_W  = 2;
    localparam int SCORE_W = 31;
    localparam int STAGE_W = 16;
    localparam int NAME_W  = 64;
    localparam int IDX_W   = 4;
    localparam int PLACE_W = 4;

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;

    typedef logic [AW-1:0] t_addr;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [STAGE_W-1:0] stage;
        logic [NAME_W-1:0]  name;
    } t_entry;

    typedef struct packed {
        logic   we;
        t_addr  waddr;
        t_addr  raddr;
        t_entry wdata;
    } t_tab_req;

    function automatic t_entry default_entry(input int unsigned idx);
        t_entry e;
        e.score = SCORE_W'((TABLE_ENTRIES - idx) * 10000);
        e.stage = STAGE_W'(TABLE_ENTRIES - idx);
        e.name  = '0;
        return e;
    endfunction

    // keep bytes up to the first zero byte, at most NAME_CHARS of them
    function automatic logic [NAME_W-1:0] clean_name(input logic [NAME_W-1:0] raw);
        logic [NAME_W-1:0] kept;
        logic              keep;
        kept = '0;
        keep = 1'b1;
        for (int b = 0; b < 8; b++) begin
            if (b >= NAME_CHARS || raw[8*b +: 8] == 8'd0) begin
                keep = 1'b0;
            end
            if (keep) begin
                kept[8*b +: 8] = raw[8*b +: 8];
            end
        end
        return kept;
    endfunction

endpackage

// ===== design/tksi_ifs.sv =====
// ----------------------------------------------------------------------------
// tksi_ifs: request and result channels of the top-k sorted insert block
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface tksi_in_if;
    logic                         valid;
    logic                         ready;
    logic [tksi_pkg::FUNC_W-1:0]  func;
    logic [tksi_pkg::SCORE_W-1:0] new_score;
    logic [tksi_pkg::STAGE_W-1:0] new_stage;
    logic [tksi_pkg::NAME_W-1:0]  new_name;
    logic [tksi_pkg::IDX_W-1:0]   read_index;

    modport source (output valid, func, new_score, new_stage, new_name, read_index,
                    input ready);
    modport sink   (input valid, func, new_score, new_stage, new_name, read_index,
                    output ready);
endinterface

interface tksi_out_if;
    logic                         valid;
    logic                         ready;
    logic                         entered;
    logic [tksi_pkg::PLACE_W-1:0] place;
    logic [tksi_pkg::SCORE_W-1:0] entry_score;
    logic [tksi_pkg::STAGE_W-1:0] entry_stage;
    logic [tksi_pkg::NAME_W-1:0]  entry_name;

    modport source (output valid, entered, place, entry_score, entry_stage, entry_name,
                    input ready);
    modport sink   (input valid, entered, place, entry_score, entry_stage, entry_name,
                    output ready);
endinterface

// ===== design/tksi_cmp.sv =====
// ----------------------------------------------------------------------------
// tksi_cmp: shared rank comparator
// Flags a candidate that beats a stored entry: higher score, or equal score
// with higher stage.
// ----------------------------------------------------------------------------
module tksi_cmp (
    input  logic [tksi_pkg::SCORE_W-1:0] i_cand_score,
    input  logic [tksi_pkg::STAGE_W-1:0] i_cand_stage,
    input  tksi_pkg::t_entry             i_entry,
    output logic                         o_beats
);
    import tksi_pkg::*;

    assign o_beats = (i_cand_score > i_entry.score) ||
                     ((i_cand_score == i_entry.score) && (i_cand_stage > i_entry.stage));

endmodule

// ===== design/tksi_table.sv =====
// ----------------------------------------------------------------------------
// tksi_table: score table storage
// One read port and one write port; reset loads the descending defaults.
// ----------------------------------------------------------------------------
module tksi_table (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tksi_pkg::t_tab_req i_req,
    output tksi_pkg::t_entry   o_rdata
);
    import tksi_pkg::*;

    t_entry r_tab [TABLE_ENTRIES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                r_tab[i] <= default_entry(i);
            end
        end else if (i_req.we) begin
            r_tab[i_req.waddr] <= i_req.wdata;
        end
    end

    assign o_rdata = r_tab[i_req.raddr];

endmodule

// ===== design/top_k_sorted_insert.sv =====
// ----------------------------------------------------------------------------
// top_k_sorted_insert: high-score table with query, insert and read
// Sequencer walks the table with one shared comparator; for an insert it then
// shifts the lower entries down one per cycle and writes the new record.
//
//   channel   dir   handshake                payload
//   i_item    in    valid/ready (sink)       func, new_score, new_stage,
//                                            new_name, read_index
//   o_res     out   valid/ready (source)     entered, place, entry_score,
//                                            entry_stage, entry_name
//
// One item per pass: a capture step, scan steps up to the place, then for
// an insert one shift step per entry below the place and a write step,
// then the result step. The walk goes through the single table port. A
// read goes from capture straight to the result step.
// Reset loads the default table. The result sits in an output register;
// the next item is taken while it waits, and the sequencer only stalls
// at the result step while that register is still full.
// ----------------------------------------------------------------------------
module top_k_sorted_insert (
    input  logic  i_clk,
    input  logic  i_rst_n,
    tksi_in_if.sink    i_item,
    tksi_out_if.source o_res
);
    import tksi_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_SHIFT = 5'b00100,
        S_WRITE = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    localparam t_addr LAST = AW'(TABLE_ENTRIES - 1);

    t_state r_state, n_state;
    logic   r_o_valid, n_o_valid;

    logic [FUNC_W-1:0]  r_func, n_func;
    logic [SCORE_W-1:0] r_score, n_score;
    logic [STAGE_W-1:0] r_stage, n_stage;
    logic [NAME_W-1:0]  r_name, n_name;
    logic               r_rd_ok, n_rd_ok;
    logic               r_entered, n_entered;
    t_addr              r_place, n_place;
    t_addr              r_addr, n_addr;

    logic               r_o_entered, n_o_entered;
    logic [PLACE_W-1:0] r_o_place, n_o_place;
    t_entry             r_o_entry, n_o_entry;

    t_tab_req tab_req;
    t_entry   tab_rdata;
    logic     beats;

    tksi_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (tab_req),
        .o_rdata (tab_rdata)
    );

    tksi_cmp u_cmp (
        .i_cand_score (r_score),
        .i_cand_stage (r_stage),
        .i_entry      (tab_rdata),
        .o_beats      (beats)
    );

    always_comb begin
        n_state     = r_state;
        n_o_valid   = r_o_valid & ~o_res.ready;
        n_func      = r_func;
        n_score     = r_score;
        n_stage     = r_stage;
        n_name      = r_name;
        n_rd_ok     = r_rd_ok;
        n_entered   = r_entered;
        n_place     = r_place;
        n_addr      = r_addr;
        n_o_entered = r_o_entered;
        n_o_place   = r_o_place;
        n_o_entry   = r_o_entry;

        tab_req.we    = 1'b0;
        tab_req.waddr = r_addr;
        tab_req.raddr = r_addr;
        tab_req.wdata = tab_rdata;

        case (r_state)
            S_IDLE: begin
                if (i_item.valid) begin
                    n_func    = i_item.func;
                    n_score   = i_item.new_score;
                    n_stage   = i_item.new_stage;
                    n_name    = clean_name(i_item.new_name);
                    n_rd_ok   = 32'(i_item.read_index) < 32'(TABLE_ENTRIES);
                    n_entered = 1'b0;
                    n_place   = '0;
                    n_addr    = '0;
                    case (i_item.func)
                        FUNC_QUERY, FUNC_INSERT: begin
                            n_state = S_SCAN;
                        end
                        FUNC_READ: begin
                            if (n_rd_ok) begin
                                n_addr = AW'(i_item.read_index);
                            end
                            n_state = S_DONE;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (beats) begin
                    n_entered = 1'b1;
                    n_place   = r_addr;
                    if (r_func == FUNC_INSERT) begin
                        if (r_addr == LAST) begin
                            n_state = S_WRITE;
                        end else begin
                            n_addr  = LAST;
                            n_state = S_SHIFT;
                        end
                    end else begin
                        n_state = S_DONE;
                    end
                end else if (r_addr == LAST) begin
                    n_state = S_DONE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_SHIFT: begin
                // entry[addr] <= entry[addr-1]
                tab_req.raddr = r_addr - 1'b1;
                tab_req.we    = 1'b1;
                if ((r_addr - 1'b1) == r_place) begin
                    n_state = S_WRITE;
                end else begin
                    n_addr = r_addr - 1'b1;
                end
            end
            S_WRITE: begin
                tab_req.we          = 1'b1;
                tab_req.waddr       = r_place;
                tab_req.wdata.score = r_score;
                tab_req.wdata.stage = r_stage;
                tab_req.wdata.name  = r_name;
                n_state             = S_DONE;
            end
            S_DONE: begin
                if (!r_o_valid || o_res.ready) begin
                    n_o_valid   = 1'b1;
                    n_o_entered = r_entered;
                    n_o_place   = r_entered ? PLACE_W'(r_place) : '0;
                    n_o_entry   = (r_func == FUNC_READ && r_rd_ok) ? tab_rdata : '0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func      <= n_func;
        r_score     <= n_score;
        r_stage     <= n_stage;
        r_name      <= n_name;
        r_rd_ok     <= n_rd_ok;
        r_entered   <= n_entered;
        r_place     <= n_place;
        r_addr      <= n_addr;
        r_o_entered <= n_o_entered;
        r_o_place   <= n_o_place;
        r_o_entry   <= n_o_entry;
    end

    assign i_item.ready      = (r_state == S_IDLE);
    assign o_res.valid       = r_o_valid;
    assign o_res.entered     = r_o_entered;
    assign o_res.place       = r_o_place;
    assign o_res.entry_score = r_o_entry.score;
    assign o_res.entry_stage = r_o_entry.stage;
    assign o_res.entry_name  = r_o_entry.name;

endmodule

// ===== tb/tb_top_k_sorted_insert.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top_k_sorted_insert: self-checking bench for the high-score table block
// Drives queries, inserts and reads through the item channel and keeps its own
// copy of the ranked table to predict every result. A short directed pass
// covers reset contents, ties, extremes, name trimming, out-of-range reads
// and the unused function code. A long random pass follows, with candidates
// drawn near stored scores so that ties and shifts are common. Both channels
// stall in random bursts. The output side also holds off for a long stretch,
// and the input side drains the block fully now and then.
// ----------------------------------------------------------------------------
module tb_top_k_sorted_insert;
    import tksi_pkg::*;

    localparam int CLK_PERIOD  = 12;
    localparam int N_RANDOM    = 1426;
    localparam int HOLD_AT     = 180;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_AT_A  = 520;
    localparam int DRAIN_AT_B  = 1010;
    localparam int QUIET_TAIL  = 200;

    localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [SCORE_W-1:0] score;
        logic [STAGE_W-1:0] stage;
        logic [NAME_W-1:0]  name;
        logic [IDX_W-1:0]   idx;
    } cmd_t;

    typedef struct packed {
        logic               entered;
        logic [PLACE_W-1:0] place;
        logic [SCORE_W-1:0] score;
        logic [STAGE_W-1:0] stage;
        logic [NAME_W-1:0]  name;
    } outcome_t;

    typedef struct packed {
        cmd_t     cmd;
        logic     typed;
        outcome_t want;
    } dir_row_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tksi_in_if  item_ch ();
    tksi_out_if res_ch ();

    top_k_sorted_insert dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_ch),
        .o_res   (res_ch)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    t_entry   hs_table [TABLE_ENTRIES];
    outcome_t expected_results [$];
    dir_row_t dir_rows [$];

    bit idle_on;
    bit hold_req;
    int fail_cnt;
    int n_results;
    int n_holds;
    int n_drains;
    int n_inserts, n_placed, n_queries, n_reads, n_oor_reads, n_unused;

    function automatic logic [NAME_W-1:0] trim_name(input logic [NAME_W-1:0] raw);
        logic [NAME_W-1:0] kept;
        int n;
        kept = '0;
        n = 0;
        while (n < NAME_CHARS && n < 8 && raw[8*n +: 8] != 8'h00) begin
            kept[8*n +: 8] = raw[8*n +: 8];
            n++;
        end
        return kept;
    endfunction

    // ranks the candidate against the table and applies an insert, or looks up a read
    function automatic outcome_t predict_outcome(input cmd_t c);
        outcome_t o;
        int p;
        o = '0;
        if (c.func == FUNC_QUERY || c.func == FUNC_INSERT) begin
            p = TABLE_ENTRIES;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (p == TABLE_ENTRIES &&
                    (c.score > hs_table[i].score ||
                     (c.score == hs_table[i].score && c.stage > hs_table[i].stage))) begin
                    p = i;
                end
            end
            if (p < TABLE_ENTRIES) begin
                o.entered = 1'b1;
                o.place   = PLACE_W'(p);
                if (c.func == FUNC_INSERT) begin
                    for (int j = TABLE_ENTRIES - 1; j > p; j--) begin
                        hs_table[j] = hs_table[j-1];
                    end
                    hs_table[p].score = c.score;
                    hs_table[p].stage = c.stage;
                    hs_table[p].name  = trim_name(c.name);
                end
            end
        end else if (c.func == FUNC_READ) begin
            if (c.idx < TABLE_ENTRIES) begin
                o.score = hs_table[c.idx].score;
                o.stage = hs_table[c.idx].stage;
                o.name  = hs_table[c.idx].name;
            end
        end
        return o;
    endfunction

    function automatic cmd_t mk_cmd(input logic [FUNC_W-1:0] f, input logic [SCORE_W-1:0] s,
                                    input logic [STAGE_W-1:0] st, input logic [NAME_W-1:0] n,
                                    input logic [IDX_W-1:0] ix);
        cmd_t c;
        c.func  = f;
        c.score = s;
        c.stage = st;
        c.name  = n;
        c.idx   = ix;
        return c;
    endfunction

    function automatic outcome_t mk_out(input logic e, input logic [PLACE_W-1:0] p,
                                        input logic [SCORE_W-1:0] s,
                                        input logic [STAGE_W-1:0] st,
                                        input logic [NAME_W-1:0] n);
        outcome_t o;
        o.entered = e;
        o.place   = p;
        o.score   = s;
        o.stage   = st;
        o.name    = n;
        return o;
    endfunction

    function automatic void add_row(input cmd_t c, input logic typed, input outcome_t w);
        dir_row_t r;
        r.cmd   = c;
        r.typed = typed;
        r.want  = w;
        dir_rows.push_back(r);
    endfunction

    task automatic offer(input cmd_t c, input logic typed, input outcome_t want);
        outcome_t pred;
        item_ch.valid      <= 1'b1;
        item_ch.func       <= c.func;
        item_ch.new_score  <= c.score;
        item_ch.new_stage  <= c.stage;
        item_ch.new_name   <= c.name;
        item_ch.read_index <= c.idx;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        pred = predict_outcome(c);
        expected_results.push_back(typed ? want : pred);
        case (c.func)
            FUNC_INSERT: begin
                n_inserts++;
                if (pred.entered) n_placed++;
            end
            FUNC_QUERY: n_queries++;
            FUNC_READ: begin
                n_reads++;
                if (c.idx >= TABLE_ENTRIES) n_oor_reads++;
            end
            default: n_unused++;
        endcase
    endtask

    task automatic sender_gap();
        if (idle_on && $urandom_range(0, 99) < 15) begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
    endtask

    task automatic check_field(input string fld, input logic [63:0] want_v,
                               input logic [63:0] got_v);
        if (want_v !== got_v) begin
            fail_cnt++;
            $error("%s: expected 0x%0h, got 0x%0h", fld, want_v, got_v);
        end
    endtask

    outcome_t want_res;

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
            n_results++;
            if (expected_results.size() == 0) begin
                fail_cnt++;
                $error("result arrived with nothing outstanding");
            end else begin
                want_res = expected_results.pop_front();
                check_field("entered", 64'(want_res.entered), 64'(res_ch.entered));
                check_field("place", 64'(want_res.place), 64'(res_ch.place));
                check_field("entry_score", 64'(want_res.score), 64'(res_ch.entry_score));
                check_field("entry_stage", 64'(want_res.stage), 64'(res_ch.entry_stage));
                check_field("entry_name", want_res.name, res_ch.entry_name);
            end
        end
    end

    // result side: random stalls plus one long hold-off on request
    initial begin
        res_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        res_ch.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                res_ch.ready <= 1'b1;
                hold_req = 1'b0;
                n_holds++;
            end else if (idle_on && $urandom_range(0, 99) < 7) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
                res_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        #(CLK_PERIOD * 400000);
        $display("FAILURE");
        $finish;
    end

    initial begin
        cmd_t c;
        int   r;
        int   m;
        int   pick;
        i_rst_n            <= 1'b0;
        item_ch.valid      <= 1'b0;
        item_ch.func       <= FUNC_QUERY;
        item_ch.new_score  <= '0;
        item_ch.new_stage  <= '0;
        item_ch.new_name   <= '0;
        item_ch.read_index <= '0;
        idle_on  = 1'b1;
        hold_req = 1'b0;

        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            hs_table[i].score = SCORE_W'((TABLE_ENTRIES - i) * 10000);
            hs_table[i].stage = STAGE_W'(TABLE_ENTRIES - i);
            hs_table[i].name  = '0;
        end

        add_row(mk_cmd(FUNC_READ, 0, 0, 0, 0), 1, mk_out(0, 0, 100000, 10, 0));
        add_row(mk_cmd(FUNC_READ, 0, 0, 0, 9), 1, mk_out(0, 0, 10000, 1, 0));
        add_row(mk_cmd(FUNC_READ, 0, 0, 0, 10), 1, '0);
        add_row(mk_cmd(FUNC_READ, '1, '1, '1, 15), 1, '0);
        add_row(mk_cmd(FUNC_NONE, '1, '1, '1, '1), 1, '0);
        add_row(mk_cmd(FUNC_QUERY, 0, 0, 0, 0), 1, '0);
        add_row(mk_cmd(FUNC_QUERY, '1, '1, '1, '1), 1, mk_out(1, 0, 0, 0, 0));
        // exact tie with the last entry does not place
        add_row(mk_cmd(FUNC_QUERY, 10000, 1, 0, 0), 1, '0);
        add_row(mk_cmd(FUNC_QUERY, 10000, 2, 0, 0), 1, mk_out(1, 9, 0, 0, 0));
        add_row(mk_cmd(FUNC_QUERY, 50000, 6, '1, 0), 1, mk_out(1, 5, 0, 0, 0));
        add_row(mk_cmd(FUNC_INSERT, 0, '1, '1, 0), 1, '0);
        add_row(mk_cmd(FUNC_READ, 0, 0, 0, 9), 1, mk_out(0, 0, 10000, 1, 0));
        add_row(mk_cmd(FUNC_INSERT, '1, '1, '1, 0), 0, '0);
        add_row(mk_cmd(FUNC_INSERT, '1, '1, 64'h41, 0), 0, '0);
        add_row(mk_cmd(FUNC_INSERT, '1, 0, 64'h5A59_5857_5655_5453, 0), 0, '0);
        add_row(mk_cmd(FUNC_INSERT, 60000, 0, 64'h4142_0043_4445_4647, 0), 0, '0);
        add_row(mk_cmd(FUNC_INSERT, 10001, 0, 64'hFFFF_FFFF_FFFF_FF00, 0), 0, '0);
        add_row(mk_cmd(FUNC_INSERT, 20000, 3, 64'h0000_0000_0043_4241, 0), 0, '0);
        add_row(mk_cmd(FUNC_READ, 0, 0, 0, 0), 0, '0);
        add_row(mk_cmd(FUNC_READ, 0, 0, 0, 1), 0, '0);
        add_row(mk_cmd(FUNC_READ, 0, 0, 0, 2), 0, '0);
        add_row(mk_cmd(FUNC_READ, 0, 0, 0, 5), 0, '0);
        add_row(mk_cmd(FUNC_READ, 0, 0, 0, 8), 0, '0);
        add_row(mk_cmd(FUNC_READ, 0, 0, 0, 9), 0, '0);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            offer(dir_rows[k].cmd, dir_rows[k].typed, dir_rows[k].want);
            sender_gap();
        end

        for (int k = 0; k < N_RANDOM; k++) begin
            idle_on = (k < N_RANDOM - QUIET_TAIL) && ((k / 250) % 3 != 2);
            if (k == HOLD_AT) hold_req = 1'b1;
            if (k == DRAIN_AT_A || k == DRAIN_AT_B) begin
                item_ch.valid <= 1'b0;
                do @(posedge i_clk); while (expected_results.size() != 0);
                n_drains++;
            end

            r = $urandom_range(0, 99);
            if (r < 40)      c.func = FUNC_INSERT;
            else if (r < 65) c.func = FUNC_QUERY;
            else if (r < 95) c.func = FUNC_READ;
            else             c.func = FUNC_NONE;

            // candidates mostly sit near a stored record to hit ties
            pick = $urandom_range(0, TABLE_ENTRIES - 1);
            m = $urandom_range(0, 9);
            if (m < 6)
                c.score = hs_table[pick].score + SCORE_W'($urandom_range(0, 4)) - SCORE_W'(2);
            else if (m == 6)
                c.score = ($urandom_range(0, 1) != 0) ? '1 : '0;
            else
                c.score = SCORE_W'($urandom());
            if ($urandom_range(0, 1) != 0)
                c.stage = hs_table[pick].stage + STAGE_W'($urandom_range(0, 2)) - STAGE_W'(1);
            else
                c.stage = STAGE_W'($urandom());

            c.name = {$urandom(), $urandom()};
            m = $urandom_range(0, 9);
            if (m < 4)       c.name[8*$urandom_range(0, 7) +: 8] = 8'h00;
            else if (m == 4) c.name = '0;

            if ($urandom_range(0, 9) < 8) c.idx = IDX_W'($urandom_range(0, TABLE_ENTRIES - 1));
            else                          c.idx = IDX_W'($urandom_range(0, 15));

            offer(c, 1'b0, '0);
            sender_gap();
        end

        item_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (4 * TABLE_ENTRIES) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            fail_cnt++;
            $error("%0d results never arrived", expected_results.size());
        end

        $display("Ran %0d items, %0d results: %0d inserts (%0d placed), %0d queries,",
                 n_inserts + n_queries + n_reads + n_unused, n_results,
                 n_inserts, n_placed, n_queries);
        $display("%0d reads (%0d out of range), %0d unused func, %0d long holds, %0d drains.",
                 n_reads, n_oor_reads, n_unused, n_holds, n_drains);
        if (fail_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
